/* hdl/ahs_pkg.sv */
// Shared types and constants of the access point handoff selector.
// Used by the controller, the datapath and the top level; depends on nothing.
package ahs_pkg;

	localparam logic signed [15:0] SCORE_INIT = 16'sd9999;
	localparam logic [15:0]        LOCK_RESET = 16'd1000;
	localparam int                 SCORE_W    = 9;
	localparam int                 DIV_W      = 16;
	localparam int                 STEP_W     = 4;

	localparam int                 REG_W         = 3;
	localparam logic [REG_W-1:0]   REG_INTERVAL  = 3'd0;
	localparam logic [REG_W-1:0]   REG_LOCK_MS   = 3'd1;
	localparam logic [REG_W-1:0]   REG_FIRST_AP0 = 3'd2;
	localparam logic [REG_W-1:0]   REG_FIRST_AP1 = 3'd3;
	localparam logic [REG_W-1:0]   REG_FIRST_AP2 = 3'd4;
	localparam logic [REG_W-1:0]   REG_FIRST_AP3 = 3'd5;

	localparam logic FUNC_STATUS = 1'b0;
	localparam logic FUNC_ACK    = 1'b1;

	typedef enum logic [1:0] {
		PH_CUR,
		PH_LEFT,
		PH_RIGHT
	} phase_t;

	typedef struct packed {
		logic   capture;
		logic   write;
		logic   div_step;
		logic   rd_issue;
		logic   acc;
		logic   decide;
		logic   emit;
		phase_t ph;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic blocked;
		logic manual;
		logic change;
		logic out_free;
	} sts_t;

endpackage

/* hdl/ahs_if.sv */
// Handshake channels of the handoff selector: status/ack items in, switch commands out.
// Depends on nothing.
interface ahs_in_if;
	logic              valid;
	logic              ready;
	logic              func;
	logic [1:0]        client_id;
	logic [2:0]        ap_index;
	logic signed [7:0] signal_level;
	logic [31:0]       time_ms;
	modport source (output valid, func, client_id, ap_index, signal_level, time_ms,
		input ready);
	modport sink (input valid, func, client_id, ap_index, signal_level, time_ms,
		output ready);
endinterface

interface ahs_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] dest_ap;
	logic [1:0] switch_client;
	logic [2:0] new_ap;
	modport source (output valid, dest_ap, switch_client, new_ap, input ready);
	modport sink (input valid, dest_ap, switch_client, new_ap, output ready);
endinterface

/* hdl/ahs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ahs_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/ahs_ctrl.sv */
// Sequencer of the handoff selector: walks each item through write, compare or divide,
// decide and emit. Depends on ahs_pkg.
module ahs_ctrl #(
	parameter int WINDOW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  ahs_pkg::sts_t       sts,
	output ahs_pkg::cmd_t       cmd,
	output logic [(WINDOW > 1 ? $clog2(WINDOW) : 1)-1:0] j
);

	localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_DIV,
		ST_RD,
		ST_ACC,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	state_t                     st_q;
	logic [ahs_pkg::STEP_W-1:0] step_q;
	logic [PW-1:0]              j_q;
	ahs_pkg::phase_t            ph_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			step_q <= '0;
			j_q    <= '0;
			ph_q   <= ahs_pkg::PH_CUR;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (item_valid) st_q <= ST_WRITE;
				end
				ST_WRITE: begin
					step_q <= '0;
					j_q    <= '0;
					ph_q   <= ahs_pkg::PH_CUR;
					if (sts.skip || sts.blocked) st_q <= ST_IDLE;
					else if (sts.manual) st_q <= ST_DIV;
					else st_q <= ST_RD;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (int'(step_q) == ahs_pkg::DIV_W - 1) st_q <= ST_DECIDE;
				end
				ST_RD: begin
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					unique case (ph_q)
						ahs_pkg::PH_CUR: begin
							ph_q <= ahs_pkg::PH_LEFT;
							st_q <= ST_RD;
						end
						ahs_pkg::PH_LEFT: begin
							ph_q <= ahs_pkg::PH_RIGHT;
							st_q <= ST_RD;
						end
						default: begin
							ph_q <= ahs_pkg::PH_CUR;
							if (int'(j_q) == WINDOW - 1) begin
								st_q <= ST_DECIDE;
							end else begin
								j_q  <= j_q + 1'b1;
								st_q <= ST_RD;
							end
						end
					endcase
				end
				ST_DECIDE: begin
					st_q <= sts.change ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (sts.out_free) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.capture  = (st_q == ST_IDLE) && item_valid;
		cmd.write    = (st_q == ST_WRITE);
		cmd.div_step = (st_q == ST_DIV);
		cmd.rd_issue = (st_q == ST_RD);
		cmd.acc      = (st_q == ST_ACC);
		cmd.decide   = (st_q == ST_DECIDE);
		cmd.emit     = (st_q == ST_EMIT) && sts.out_free;
		cmd.ph       = ph_q;
	end

	assign item_ready = (st_q == ST_IDLE);
	assign j          = j_q;

	a_accept_write: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (st_q == ST_WRITE))
		else $error("accepted beat did not enter the write step");

endmodule

/* hdl/ahs_datapath.sv */
// Datapath of the handoff selector: score RAM with valid bits, ring pointers, client state,
// compare/sum accumulators, serial remainder unit and the output register.
// Depends on ahs_pkg and ahs_ram.
module ahs_datapath #(
	parameter int CLIENTS = 4,
	parameter int APS     = 8,
	parameter int WINDOW  = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ahs_pkg::cmd_t                  cmd,
	input  logic [(WINDOW > 1 ? $clog2(WINDOW) : 1)-1:0] j,
	output ahs_pkg::sts_t                  sts,
	input  logic                           func,
	input  logic [1:0]                     client_id,
	input  logic [2:0]                     ap_index,
	input  logic signed [7:0]              signal_level,
	input  logic [31:0]                    time_ms,
	input  logic                           cfg_we,
	input  logic [ahs_pkg::REG_W-1:0]      cfg_idx,
	input  logic [15:0]                    cfg_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     dest_ap,
	output logic [1:0]                     switch_client,
	output logic [2:0]                     new_ap
);

	localparam int CW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
	localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int RN = CLIENTS * APS;
	localparam int RW = $clog2(RN);
	localparam int D  = RN * WINDOW;
	localparam int AW = $clog2(D);
	localparam int SW = 17 + $clog2(WINDOW);
	localparam int SC = ahs_pkg::SCORE_W;

	// captured item
	logic              func_q;
	logic [1:0]        cl_q;
	logic [2:0]        ap_q;
	logic signed [7:0] lvl_q;
	logic [31:0]       now_q;

	// configuration and control state
	logic [15:0]   interval_q;
	logic [15:0]   lock_ms_q;
	logic [15:0]   count_q;
	logic [PW-1:0] ptr_q [RN];
	logic [D-1:0]  vld_q;
	logic          pending_q [CLIENTS];
	logic          locked_q [CLIENTS];
	logic [31:0]   lock_start_q [CLIENTS];
	logic [2:0]    cur_ap_q [CLIENTS];
	logic          out_vld_q;

	// accumulators, divider, result
	logic signed [15:0] cur_sc_q;
	logic               left_ok_q;
	logic               right_ok_q;
	logic signed [SW-1:0] sum_l_q;
	logic signed [SW-1:0] sum_r_q;
	logic [15:0]        num_q;
	logic [15:0]        rem_q;
	logic [2:0]         res_dest_q;
	logic [2:0]         res_new_q;
	logic [2:0]         out_dest_q;
	logic [1:0]         out_cl_q;
	logic [2:0]         out_new_q;
	logic               rd_vld_s1;

	logic [CW-1:0]      ci;
	logic               c_ok;
	logic               a_ok;
	logic               skip;
	logic [RW-1:0]      ridx;
	logic [PW-1:0]      p;
	logic [PW-1:0]      p_next;
	logic signed [SC-1:0] sig9;
	logic signed [SC-1:0] score_wr;
	logic               expired;
	logic               blocked;
	logic [2:0]         cur;
	logic               has_l;
	logic               has_r;
	logic [2:0]         rd_ap;
	logic [PW-1:0]      rd_pos;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic               ram_we;
	logic [SC-1:0]      rdata;
	logic signed [15:0] rd_score;
	logic [16:0]        rem_sh;
	logic               go_l;
	logic               go_r;
	logic [2:0]         best;
	logic               change;
	logic [2:0]         cfg_k;
	logic [2:0]         cfg_ap;

	assign ci      = cl_q[CW-1:0];
	assign c_ok    = int'(cl_q) < CLIENTS;
	assign a_ok    = int'(ap_q) < APS;
	assign skip    = !c_ok || (func_q == ahs_pkg::FUNC_ACK) || !a_ok;
	assign ridx    = RW'(int'(cl_q) * APS + int'(ap_q));
	assign p       = ptr_q[ridx];
	assign p_next  = (int'(p) == WINDOW - 1) ? '0 : p + 1'b1;
	assign sig9    = {lvl_q[7], lvl_q};
	assign score_wr = -sig9;
	assign expired = (now_q - lock_start_q[ci]) > {16'd0, lock_ms_q};
	assign blocked = pending_q[ci] || (locked_q[ci] && !expired);

	assign cur   = cur_ap_q[ci];
	assign has_l = (cur != 3'd0);
	assign has_r = int'(cur) < APS - 1;

	// neighbor rings are walked back to front against the current ring
	always_comb begin
		unique case (cmd.ph)
			ahs_pkg::PH_CUR: begin
				rd_ap  = cur;
				rd_pos = j;
			end
			ahs_pkg::PH_LEFT: begin
				rd_ap  = has_l ? cur - 3'd1 : cur;
				rd_pos = PW'(WINDOW - 1) - j;
			end
			default: begin
				rd_ap  = has_r ? cur + 3'd1 : cur;
				rd_pos = PW'(WINDOW - 1) - j;
			end
		endcase
	end

	assign waddr  = AW'((int'(cl_q) * APS + int'(ap_q)) * WINDOW + int'(p));
	assign raddr  = AW'((int'(cl_q) * APS + int'(rd_ap)) * WINDOW + int'(rd_pos));
	assign ram_we = cmd.write && !skip;

	ahs_ram #(.WIDTH(SC), .DEPTH(D)) u_score_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (score_wr),
		.re    (cmd.rd_issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	// unwritten entries read as the reset score
	assign rd_score = rd_vld_s1 ? 16'(signed'(rdata)) : ahs_pkg::SCORE_INIT;

	assign rem_sh = {rem_q, num_q[15]};

	always_comb begin
		go_l = has_l && left_ok_q;
		go_r = has_r && right_ok_q;
		if (go_l && go_r) begin
			if (sum_l_q <= sum_r_q) go_r = 1'b0;
			else go_l = 1'b0;
		end
		if (interval_q != 16'd0) begin
			best = (rem_q == 16'd0) ? {2'b00, ~cur[0]} : cur;
		end else if (go_l) begin
			best = cur - 3'd1;
		end else if (go_r) begin
			best = cur + 3'd1;
		end else begin
			best = cur;
		end
	end

	assign change = (best != cur);
	assign cfg_k  = cfg_idx - ahs_pkg::REG_FIRST_AP0;
	assign cfg_ap = (int'(cfg_data[2:0]) >= APS) ? 3'(APS - 1) : cfg_data[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= '0;
			lock_ms_q  <= ahs_pkg::LOCK_RESET;
			count_q    <= '0;
			vld_q      <= '0;
			out_vld_q  <= 1'b0;
			rd_vld_s1  <= 1'b0;
			for (int i = 0; i < RN; i++) ptr_q[i] <= '0;
			for (int i = 0; i < CLIENTS; i++) begin
				pending_q[i]    <= 1'b0;
				locked_q[i]     <= 1'b0;
				lock_start_q[i] <= '0;
				cur_ap_q[i]     <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_idx == ahs_pkg::REG_INTERVAL) interval_q <= cfg_data;
				else if (cfg_idx == ahs_pkg::REG_LOCK_MS) lock_ms_q <= cfg_data;
				else if (cfg_idx >= ahs_pkg::REG_FIRST_AP0 && cfg_idx <= ahs_pkg::REG_FIRST_AP3
					&& int'(cfg_k) < CLIENTS) begin
					cur_ap_q[cfg_k[CW-1:0]] <= cfg_ap;
				end
			end
			if (cmd.write) begin
				if (c_ok && func_q == ahs_pkg::FUNC_ACK) pending_q[ci] <= 1'b0;
				if (!skip) begin
					vld_q[waddr] <= 1'b1;
					ptr_q[ridx]  <= p_next;
					count_q      <= count_q + 16'd1;
					if (expired) locked_q[ci] <= 1'b0;
				end
			end
			if (cmd.rd_issue) rd_vld_s1 <= vld_q[raddr];
			if (cmd.decide && change) begin
				pending_q[ci]    <= 1'b1;
				locked_q[ci]     <= 1'b1;
				lock_start_q[ci] <= now_q;
				cur_ap_q[ci]     <= best;
			end
			if (cmd.emit) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			cl_q   <= client_id;
			ap_q   <= ap_index;
			lvl_q  <= signal_level;
			now_q  <= time_ms;
		end
		if (cmd.write) begin
			left_ok_q  <= 1'b1;
			right_ok_q <= 1'b1;
			sum_l_q    <= '0;
			sum_r_q    <= '0;
			num_q      <= count_q + 16'd1;
			rem_q      <= '0;
		end
		if (cmd.div_step) begin
			num_q <= {num_q[14:0], 1'b0};
			if (rem_sh >= {1'b0, interval_q}) rem_q <= 16'(rem_sh - {1'b0, interval_q});
			else rem_q <= rem_sh[15:0];
		end
		if (cmd.acc) begin
			unique case (cmd.ph)
				ahs_pkg::PH_CUR: cur_sc_q <= rd_score;
				ahs_pkg::PH_LEFT: begin
					if (rd_score >= cur_sc_q) left_ok_q <= 1'b0;
					sum_l_q <= sum_l_q + SW'(rd_score);
				end
				default: begin
					if (rd_score >= cur_sc_q) right_ok_q <= 1'b0;
					sum_r_q <= sum_r_q + SW'(rd_score);
				end
			endcase
		end
		if (cmd.decide) begin
			res_dest_q <= cur;
			res_new_q  <= best;
		end
		if (cmd.emit) begin
			out_dest_q <= res_dest_q;
			out_cl_q   <= cl_q;
			out_new_q  <= res_new_q;
		end
	end

	always_comb begin
		sts          = '0;
		sts.skip     = skip;
		sts.blocked  = blocked;
		sts.manual   = (interval_q != 16'd0);
		sts.change   = change;
		sts.out_free = !out_vld_q || out_ready;
	end

	assign out_valid     = out_vld_q;
	assign dest_ap       = out_dest_q;
	assign switch_client = out_cl_q;
	assign new_ap        = out_new_q;

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < interval_q))
		else $error("remainder reached the divisor");

	a_real_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_new_q != out_dest_q))
		else $error("switch command names the same AP twice");

endmodule

/* hdl/ap_handoff_selector.sv */
// Top level of the access point handoff selector.
// Depends on ahs_pkg, ahs_if, ahs_ram, ahs_ctrl and ahs_datapath.
//
// Usage:
//  - item (sink): status reports (func 0) and switch acknowledges (func 1) per client.
//    A beat is taken when valid and ready are both high; ready is high only while the
//    sequencer is idle, so one item is in work at a time.
//  - result (source): one switch command beat (dest_ap, switch_client, new_ap) per
//    handover, held in an output register until taken.
//  - cfg_we/cfg_idx/cfg_data: register writes, index 0 interval, 1 lock time,
//    2..5 first AP of clients 0..3 (also loads that client's current AP at once).
// Steps per item, after the accepting edge:
//  - ignored items, acknowledges and locked or pending clients: the write step only.
//  - manual mode: write, a divide step per numerator bit, decide; paced by the bit-serial remainder unit.
//  - adaptive mode: write, then a read step and an accumulate step for each of the three reads
//    per window slot (current, left and right ring), then decide; the score RAM has a single read port.
//  - a change adds the emit step that loads the output register.
// A new item is accepted while an earlier command still waits; only the next change
// waits in the emit step until the receiver frees the output register.
// Reset clears the score valid bits at once (all scores read as 9999), client state,
// ring pointers and the status count; no clearing pass is needed.
module ap_handoff_selector #(
	parameter int CLIENTS = 4,
	parameter int APS     = 8,
	parameter int WINDOW  = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ahs_in_if.sink                    item,
	ahs_out_if.source                 result,
	input  logic                      cfg_we,
	input  logic [ahs_pkg::REG_W-1:0] cfg_idx,
	input  logic [15:0]               cfg_data
);

	localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	ahs_pkg::cmd_t cmd;
	ahs_pkg::sts_t sts;
	logic [PW-1:0] j;

	// sequencer: owns item ready and every step of the walk
	ahs_ctrl #(.WINDOW(WINDOW)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd),
		.j          (j)
	);

	// datapath: state, score RAM, remainder unit and the output register
	ahs_datapath #(.CLIENTS(CLIENTS), .APS(APS), .WINDOW(WINDOW)) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.j             (j),
		.sts           (sts),
		.func          (item.func),
		.client_id     (item.client_id),
		.ap_index      (item.ap_index),
		.signal_level  (item.signal_level),
		.time_ms       (item.time_ms),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.dest_ap       (result.dest_ap),
		.switch_client (result.switch_client),
		.new_ap        (result.new_ap)
	);

endmodule
